FILE: rtl/core/nls_pkg.sv
// Shared types and character codes for the numeric literal scanner.
package nls_pkg;

   typedef enum logic [8:0] {
      MODE_IDLE       = 9'b000000001,
      MODE_INT        = 9'b000000010,
      MODE_HEX        = 9'b000000100,
      MODE_DOT        = 9'b000001000,
      MODE_VARARG     = 9'b000010000,
      MODE_FRAC       = 9'b000100000,
      MODE_EXP_START  = 9'b001000000,
      MODE_EXP_SIGN   = 9'b010000000,
      MODE_EXP_DIGITS = 9'b100000000
   } mode_type;

   localparam logic [2:0] KIND_INT        = 3'd0;
   localparam logic [2:0] KIND_FLOAT      = 3'd1;
   localparam logic [2:0] KIND_DOT        = 3'd2;
   localparam logic [2:0] KIND_VARARG     = 3'd3;
   localparam logic [2:0] KIND_BAD_EXP    = 3'd4;
   localparam logic [2:0] KIND_BAD_VARARG = 3'd5;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_E  = 8'h65;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_H  = 8'h68;
   localparam logic [7:0] CHAR_LO_L  = 8'h6c;
   localparam logic [7:0] CHAR_LO_U  = 8'h75;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_UP_H  = 8'h48;
   localparam logic [7:0] CHAR_UP_L  = 8'h4c;
   localparam logic [7:0] CHAR_UP_U  = 8'h55;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] length;
      logic       taken;
   } step_result_type;

endpackage

FILE: rtl/core/nls_step.sv
// Next-state and token result logic for one scanned word.
module nls_step #(
   parameter int LENGTH_LIMIT = 255,
   parameter int CNT_W = 8
) (
   input  nls_pkg::mode_type        mode,
   input  logic [CNT_W-1:0]         count,
   input  logic                     only_zero,
   input  logic [7:0]               character,
   output nls_pkg::mode_type        mode_next,
   output logic [CNT_W-1:0]         count_next,
   output logic                     only_zero_next,
   output nls_pkg::step_result_type result
);

   localparam int WIDE_W = (CNT_W > 8) ? CNT_W : 8;

   logic             is_dec;
   logic             is_hex;
   logic             is_exp;
   logic             is_sign;
   logic             is_int_sfx;
   logic             is_flt_sfx;
   logic             is_dot;
   logic [CNT_W-1:0] count_inc;
   logic             emit;
   logic             emit_taken;
   logic [2:0]       emit_kind;
   logic             restart;
   logic [CNT_W-1:0] emit_len;
   logic [WIDE_W-1:0] emit_len_wide;

   assign is_dec     = character inside {[nls_pkg::CHAR_0 : nls_pkg::CHAR_9]};
   assign is_hex     = character inside {[nls_pkg::CHAR_0 : nls_pkg::CHAR_9],
                                         [nls_pkg::CHAR_LO_A : nls_pkg::CHAR_LO_F],
                                         [nls_pkg::CHAR_UP_A : nls_pkg::CHAR_UP_F]};
   assign is_exp     = character inside {nls_pkg::CHAR_LO_E, nls_pkg::CHAR_UP_E};
   assign is_sign    = character inside {nls_pkg::CHAR_PLUS, nls_pkg::CHAR_MINUS};
   assign is_int_sfx = character inside {nls_pkg::CHAR_LO_U, nls_pkg::CHAR_UP_U,
                                         nls_pkg::CHAR_LO_L, nls_pkg::CHAR_UP_L};
   assign is_flt_sfx = character inside {nls_pkg::CHAR_LO_F, nls_pkg::CHAR_UP_F,
                                         nls_pkg::CHAR_LO_H, nls_pkg::CHAR_UP_H,
                                         nls_pkg::CHAR_LO_L, nls_pkg::CHAR_UP_L};
   assign is_dot     = (character == nls_pkg::CHAR_DOT);

   assign count_inc = (count < CNT_W'(LENGTH_LIMIT)) ? count + CNT_W'(1) : count;

   always_comb begin
      mode_next      = mode;
      count_next     = count;
      only_zero_next = only_zero;
      emit           = 1'b0;
      emit_taken     = 1'b0;
      emit_kind      = nls_pkg::KIND_INT;
      restart        = 1'b0;
      case (mode)
         nls_pkg::MODE_INT: begin
            if (is_dec) begin
               only_zero_next = 1'b0;
               count_next     = count_inc;
            end else if (is_dot) begin
               mode_next  = nls_pkg::MODE_FRAC;
               count_next = count_inc;
            end else if (is_exp) begin
               mode_next  = nls_pkg::MODE_EXP_START;
               count_next = count_inc;
            end else if (character == nls_pkg::CHAR_LO_X && only_zero) begin
               only_zero_next = 1'b0;
               mode_next      = nls_pkg::MODE_HEX;
               count_next     = count_inc;
            end else if (is_int_sfx) begin
               emit       = 1'b1;
               emit_taken = 1'b1;
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
            end
         end
         nls_pkg::MODE_HEX: begin
            if (is_hex) begin
               count_next = count_inc;
            end else if (is_int_sfx) begin
               emit       = 1'b1;
               emit_taken = 1'b1;
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
            end
         end
         nls_pkg::MODE_DOT: begin
            emit_kind = nls_pkg::KIND_DOT;
            if (is_dot) begin
               mode_next  = nls_pkg::MODE_VARARG;
               count_next = count_inc;
            end else if (is_dec) begin
               mode_next  = nls_pkg::MODE_FRAC;
               count_next = count_inc;
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
            end
         end
         nls_pkg::MODE_VARARG: begin
            emit       = 1'b1;
            emit_taken = 1'b1;
            emit_kind  = is_dot ? nls_pkg::KIND_VARARG : nls_pkg::KIND_BAD_VARARG;
         end
         nls_pkg::MODE_FRAC, nls_pkg::MODE_EXP_DIGITS: begin
            emit_kind = nls_pkg::KIND_FLOAT;
            if (is_dec) begin
               count_next = count_inc;
            end else if (is_exp && mode == nls_pkg::MODE_FRAC) begin
               mode_next  = nls_pkg::MODE_EXP_START;
               count_next = count_inc;
            end else if (is_flt_sfx) begin
               emit       = 1'b1;
               emit_taken = 1'b1;
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
            end
         end
         nls_pkg::MODE_EXP_START, nls_pkg::MODE_EXP_SIGN: begin
            emit_kind = nls_pkg::KIND_BAD_EXP;
            if (is_sign && mode == nls_pkg::MODE_EXP_START) begin
               mode_next  = nls_pkg::MODE_EXP_SIGN;
               count_next = count_inc;
            end else if (is_dec) begin
               mode_next  = nls_pkg::MODE_EXP_DIGITS;
               count_next = count_inc;
            end else begin
               emit    = 1'b1;
               restart = 1'b1;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      if (emit || restart) begin
         mode_next      = nls_pkg::MODE_IDLE;
         count_next     = '0;
         only_zero_next = 1'b0;
      end
      if (restart) begin
         if (is_dec) begin
            mode_next      = nls_pkg::MODE_INT;
            count_next     = CNT_W'(1);
            only_zero_next = (character == nls_pkg::CHAR_0);
         end else if (is_dot) begin
            mode_next  = nls_pkg::MODE_DOT;
            count_next = CNT_W'(1);
         end
      end
   end

   assign emit_len      = emit_taken ? count_inc : count;
   assign emit_len_wide = WIDE_W'(emit_len);

   always_comb begin
      result.valid  = emit;
      result.kind   = emit_kind;
      result.taken  = emit_taken;
      result.length = (emit_len_wide > WIDE_W'(255)) ? 8'hff : emit_len_wide[7:0];
   end

endmodule

FILE: rtl/core/numeric_literal_scanner.sv
// Scans one character word per cycle unless stalled and reports C-style numeric literal, dot and vararg tokens.
// The scanner takes one character per cycle while req_stall is low and gives at most one token
// per character, in the cycle after the character is taken; the scan state and the token are both
// updated in the cycle of acceptance. req_stall rises only while a token sits in the output register and
// rsp_stall holds it; the word that frees that register may load the next token in the same
// cycle. A token that ends on a character not taken (rsp_char_taken low) restarts scanning
// on that same character. Token lengths saturate at LENGTH_LIMIT and at 255.
module numeric_literal_scanner #(
   parameter int LENGTH_LIMIT = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_length,
   output logic       rsp_char_taken
);

   localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);

   nls_pkg::mode_type        mode_ff;
   nls_pkg::mode_type        mode_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     zero_ff;
   logic                     zero_in;
   nls_pkg::step_result_type step_res;
   logic                     accept;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [2:0]               kind_ff;
   logic [7:0]               length_ff;
   logic                     taken_ff;

   nls_step #(
      .LENGTH_LIMIT(LENGTH_LIMIT),
      .CNT_W       (CNT_W)
   ) u_step (
      .mode          (mode_ff),
      .count         (count_ff),
      .only_zero     (zero_ff),
      .character     (req_character),
      .mode_next     (mode_in),
      .count_next    (count_in),
      .only_zero_next(zero_in),
      .result        (step_res)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && step_res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= nls_pkg::MODE_IDLE;
         count_ff     <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            zero_ff  <= zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_res.valid) begin
         kind_ff   <= step_res.kind;
         length_ff <= step_res.length;
         taken_ff  <= step_res.taken;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_length     = length_ff;
   assign rsp_char_taken = taken_ff;

endmodule

FILE: rtl/core/nls_checker.sv
// Port-level assertions for the numeric literal scanner, bound to the top level.
module nls_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_character,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_length,
   input logic       rsp_char_taken
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_length)
                                 && $stable(rsp_char_taken))
      else $error("stalled result word changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   a_vararg_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == nls_pkg::KIND_VARARG || rsp_kind == nls_pkg::KIND_BAD_VARARG)
      |-> rsp_length == 8'd3 && rsp_char_taken)
      else $error("vararg token with wrong length or not taken");

   a_dot_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == nls_pkg::KIND_DOT |-> rsp_length == 8'd1 && !rsp_char_taken)
      else $error("dot token malformed");

   a_bad_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == nls_pkg::KIND_BAD_EXP |-> !rsp_char_taken && rsp_length >= 8'd2)
      else $error("bad exponent token malformed");

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_character (req_character),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_length    (rsp_length),
   .rsp_char_taken(rsp_char_taken)
);
